@@ design/rce_pkg.sv @@
`timescale 1ns / 1ps

package rce_pkg;

   // fixed limits of the curves
   localparam int MAX_THROTTLE = 1850;
   localparam int PR_LAST      = 4;
   localparam int THR_LAST     = 10;
   localparam int OUT_MAX      = 2047;

   // reciprocals for the constant divisors (floor(2^S / d), rounded up for d = 10)
   localparam int PR_DIV   = 1192;
   localparam int PR_SH    = 22;
   localparam int PR_K     = (1 << PR_SH) / PR_DIV;
   localparam int TEN_SH   = 19;
   localparam int TEN_K    = ((1 << TEN_SH) + 9) / 10;
   localparam int THR_DIV  = 1000;
   localparam int THR_SH   = 24;
   localparam int THR_K    = (1 << THR_SH) / THR_DIV;

   // register indexes
   localparam logic [2:0] REG_RC_RATE       = 3'd0;
   localparam logic [2:0] REG_RC_EXPO       = 3'd1;
   localparam logic [2:0] REG_THROTTLE_MID  = 3'd2;
   localparam logic [2:0] REG_THROTTLE_EXPO = 3'd3;
   localparam logic [2:0] REG_MIN_THROTTLE  = 3'd4;

   localparam int CSR_AW = 5;

   typedef struct packed {
      logic [7:0]  rc_rate;
      logic [6:0]  rc_expo;
      logic [6:0]  throttle_mid;
      logic [6:0]  throttle_expo;
      logic [10:0] min_throttle;
   } cfg_type;

   typedef struct packed {
      logic [20:0] rem;
      logic        hit;
   } dstep_type;

   // one restoring step of the quotient: subtract d << sh when it fits
   function automatic dstep_type div_step(input logic [20:0] rem, input logic [13:0] d,
                                          input logic [2:0] sh);
      logic [21:0] t;
      dstep_type   r;
      t = 22'(d) << sh;
      if ({1'b0, rem} >= t) begin
         r.rem = 21'({1'b0, rem} - t);
         r.hit = 1'b1;
      end else begin
         r.rem = rem;
         r.hit = 1'b0;
      end
      return r;
   endfunction

   // clamp into the 11-bit output range
   function automatic logic [10:0] sat11(input logic signed [26:0] v);
      logic [10:0] r;
      if (v < 0) begin
         r = 11'd0;
      end else if (v > 27'sd2047) begin
         r = 11'(OUT_MAX);
      end else begin
         r = v[10:0];
      end
      return r;
   endfunction

endpackage

@@ design/rce_csr.sv @@
`timescale 1ns / 1ps

module rce_csr import rce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   logic [2:0] idx;
   logic       wr;

   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rc_rate       <= 8'd90;
         cfg_ff.rc_expo       <= 7'd65;
         cfg_ff.throttle_mid  <= 7'd50;
         cfg_ff.throttle_expo <= 7'd0;
         cfg_ff.min_throttle  <= 11'd1150;
      end else if (wr) begin
         case (idx)
            REG_RC_RATE:       cfg_ff.rc_rate       <= csr_pwdata[7:0];
            REG_RC_EXPO:       cfg_ff.rc_expo       <= csr_pwdata[6:0];
            REG_THROTTLE_MID:  cfg_ff.throttle_mid  <= csr_pwdata[6:0];
            REG_THROTTLE_EXPO: cfg_ff.throttle_expo <= csr_pwdata[6:0];
            REG_MIN_THROTTLE:  cfg_ff.min_throttle  <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (idx)
         REG_RC_RATE:       csr_prdata = 32'(cfg_ff.rc_rate);
         REG_RC_EXPO:       csr_prdata = 32'(cfg_ff.rc_expo);
         REG_THROTTLE_MID:  csr_prdata = 32'(cfg_ff.throttle_mid);
         REG_THROTTLE_EXPO: csr_prdata = 32'(cfg_ff.throttle_expo);
         REG_MIN_THROTTLE:  csr_prdata = 32'(cfg_ff.min_throttle);
         default:           csr_prdata = 32'd0;
      endcase
   end

endmodule

@@ design/rc_expo_curve_point.sv @@
`timescale 1ns / 1ps

// Stick response curve breakpoint generator.
// Request word: req_op selects the curve (0 pitch/roll, 1 throttle) and
// req_point the breakpoint index. Each request gives exactly one response
// word: rsp_curve_value and rsp_bad_point (index out of range, value zero).
// Words move on valid/stall handshakes; a word is taken when valid is high
// and stall is low.
// The datapath is a 12-stage pipeline that shows each request on rsp_valid
// from its last stage; one request is taken every cycle while req_stall is
// low. The depth is set by the chain of stages: the 7-bit throttle expo
// quotient (up to two bits a stage) and the reciprocal multiply and
// correction for each constant divisor.
// When the receiver stalls, words pile up in empty stages; req_stall rises
// only once every stage holds a word, so nothing is lost or repeated.
// Curve parameters sit in the CSR port (APB style, registers at 4*i) and
// must only be written while the pipeline is empty.
// Synchronous reset empties the pipeline and loads the default curve
// settings.
module rc_expo_curve_point import rce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [3:0]        req_point,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [10:0]       rsp_curve_value,
   output logic              rsp_bad_point,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int NST = 12;

   typedef struct packed {
      logic               thr;
      logic               bad;
      logic signed [7:0]  tmp;
      logic [6:0]         y;
      logic [13:0]        ysq;
      logic [13:0]        tsq;
      logic [20:0]        rem;
      logic [6:0]         q;
      logic               neg;
      logic signed [26:0] acc;
      logic [23:0]        aux;
      logic [10:0]        prv;
      logic [10:0]        res;
   } pipe_type;

   cfg_type   cfg;
   pipe_type  s_ff [1:NST];
   pipe_type  s_in [1:NST];
   logic [NST:1] v_ff;
   logic [NST:1] en;

   rce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      en[NST] = !v_ff[NST] || !rsp_stall;
      for (int k = NST - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) v_ff[1] <= req_valid;
         for (int k = 2; k <= NST; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= NST; k++) begin
         if (en[k]) s_ff[k] <= s_in[k];
      end
   end

   // stage 1: range check, offset from mid point, divisor choice, i*i-15, i*rate
   always_comb begin
      logic [7:0] p10;
      logic [7:0] pp;
      s_in[1]     = s_ff[1];
      p10         = 8'(req_point) * 8'd10;
      pp          = 8'(req_point) * 8'(req_point);
      s_in[1].thr = req_op;
      s_in[1].bad = req_op ? (req_point > 4'(THR_LAST)) : (req_point > 4'(PR_LAST));
      s_in[1].tmp = $signed(p10 - {1'b0, cfg.throttle_mid});
      if (s_in[1].tmp > 0) begin
         s_in[1].y = 7'd100 - cfg.throttle_mid;
      end else if (s_in[1].tmp < 0) begin
         s_in[1].y = cfg.throttle_mid;
      end else begin
         s_in[1].y = 7'd1;
      end
      s_in[1].acc = $signed({19'd0, pp}) - 27'sd15;
      s_in[1].aux = 24'(12'(req_point) * 12'(cfg.rc_rate));
   end

   // stage 2: squares; pitch/roll base term
   always_comb begin
      logic [6:0]         ta;
      logic signed [26:0] e;
      s_in[2]     = s_ff[1];
      ta          = s_ff[1].tmp[7] ? 7'(-s_ff[1].tmp) : s_ff[1].tmp[6:0];
      e           = $signed({20'd0, cfg.rc_expo});
      s_in[2].tsq = 14'(ta) * 14'(ta);
      s_in[2].ysq = 14'(s_ff[1].y) * 14'(s_ff[1].y);
      s_in[2].acc = 27'sd1526 + e * s_ff[1].acc;
   end

   // stage 3: expo dividend; pitch/roll product
   always_comb begin
      s_in[3]     = s_ff[2];
      s_in[3].rem = 21'(cfg.throttle_expo) * 21'(s_ff[2].tsq);
      s_in[3].q   = 7'd0;
      s_in[3].acc = s_ff[2].acc * $signed({3'd0, s_ff[2].aux});
   end

   // stage 4: quotient bits 6,5; pitch/roll estimate of /1192
   always_comb begin
      dstep_type  d6, d5;
      logic [23:0] m;
      logic [35:0] pk;
      s_in[4]      = s_ff[3];
      d6           = div_step(s_ff[3].rem, s_ff[3].ysq, 3'd6);
      d5           = div_step(d6.rem, s_ff[3].ysq, 3'd5);
      s_in[4].rem  = d5.rem;
      s_in[4].q[6] = d6.hit;
      s_in[4].q[5] = d5.hit;
      s_in[4].neg  = s_ff[3].acc < 0;
      m            = s_in[4].neg ? 24'(-s_ff[3].acc) : s_ff[3].acc[23:0];
      pk           = 36'(m) * 36'(PR_K);
      s_in[4].aux  = 24'(pk >> PR_SH);
      s_in[4].acc  = $signed({3'd0, m});
   end

   // stage 5: quotient bits 4,3; pitch/roll correction and clamp
   always_comb begin
      dstep_type          d4, d3;
      logic signed [26:0] qe, r, v;
      s_in[5]      = s_ff[4];
      d4           = div_step(s_ff[4].rem, s_ff[4].ysq, 3'd4);
      d3           = div_step(d4.rem, s_ff[4].ysq, 3'd3);
      s_in[5].rem  = d4.rem;
      s_in[5].rem  = d3.rem;
      s_in[5].q[4] = d4.hit;
      s_in[5].q[3] = d3.hit;
      qe           = $signed({3'd0, s_ff[4].aux});
      r            = s_ff[4].acc - qe * 27'sd1192;
      if (r >= 27'sd1192) qe = qe + 27'sd1;
      v            = s_ff[4].neg ? -qe : qe;
      s_in[5].prv  = sat11(v);
   end

   // stage 6: quotient bits 2,1
   always_comb begin
      dstep_type d2, d1;
      s_in[6]      = s_ff[5];
      d2           = div_step(s_ff[5].rem, s_ff[5].ysq, 3'd2);
      d1           = div_step(d2.rem, s_ff[5].ysq, 3'd1);
      s_in[6].rem  = d1.rem;
      s_in[6].q[2] = d2.hit;
      s_in[6].q[1] = d1.hit;
   end

   // stage 7: quotient bit 0
   always_comb begin
      dstep_type d0;
      s_in[7]      = s_ff[6];
      d0           = div_step(s_ff[6].rem, s_ff[6].ysq, 3'd0);
      s_in[7].rem  = d0.rem;
      s_in[7].q[0] = d0.hit;
   end

   // stage 8: inner gain times offset
   always_comb begin
      logic signed [26:0] a, b;
      s_in[8]     = s_ff[7];
      a           = 27'(s_ff[7].tmp);
      b           = $signed({20'd0, s_ff[7].q}) + 27'sd100
                    - $signed({20'd0, cfg.throttle_expo});
      s_in[8].acc = a * b;
   end

   // stage 9: /10 toward zero, add 10*mid
   always_comb begin
      logic [14:0]        m;
      logic [31:0]        pk;
      logic signed [26:0] dq, mid10;
      s_in[9]     = s_ff[8];
      m           = s_ff[8].acc[26] ? 15'(-s_ff[8].acc) : s_ff[8].acc[14:0];
      pk          = 32'(m) * 32'(TEN_K);
      dq          = $signed({12'd0, 15'(pk >> TEN_SH)});
      mid10       = $signed({20'd0, cfg.throttle_mid}) * 27'sd10;
      s_in[9].acc = mid10 + (s_ff[8].acc[26] ? -dq : dq);
   end

   // stage 10: scale by throttle span
   always_comb begin
      logic signed [26:0] span;
      s_in[10]     = s_ff[9];
      span         = 27'(MAX_THROTTLE) - $signed({16'd0, cfg.min_throttle});
      s_in[10].acc = span * s_ff[9].acc;
   end

   // stage 11: estimate of /1000
   always_comb begin
      logic [23:0] m;
      logic [39:0] pk;
      s_in[11]     = s_ff[10];
      s_in[11].neg = s_ff[10].acc < 0;
      m            = s_in[11].neg ? 24'(-s_ff[10].acc) : s_ff[10].acc[23:0];
      pk           = 40'(m) * 40'(THR_K);
      s_in[11].aux = 24'(pk >> THR_SH);
      s_in[11].acc = $signed({3'd0, m});
   end

   // stage 12: correction, offset, clamp and curve select
   always_comb begin
      logic signed [26:0] qe, r, v;
      s_in[12] = s_ff[11];
      qe       = $signed({3'd0, s_ff[11].aux});
      r        = s_ff[11].acc - qe * 27'sd1000;
      if (r >= 27'sd1000) qe = qe + 27'sd1;
      v        = $signed({16'd0, cfg.min_throttle}) + (s_ff[11].neg ? -qe : qe);
      if (s_ff[11].bad) begin
         s_in[12].res = 11'd0;
      end else if (s_ff[11].thr) begin
         s_in[12].res = sat11(v);
      end else begin
         s_in[12].res = s_ff[11].prv;
      end
   end

   assign rsp_valid       = v_ff[NST];
   assign rsp_curve_value = s_ff[NST].res;
   assign rsp_bad_point   = s_ff[NST].bad;

   // checks
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_point |-> rsp_curve_value == 11'd0)
      else $error("bad point with non-zero value");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_curve_value))
      else $error("stalled response word lost or changed");

   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v_ff[1])
      else $error("accepted request word not in first stage");

   a_room: assert property (@(posedge clock) disable iff (reset)
      !v_ff[1] |-> !req_stall)
      else $error("stall with empty first stage");

endmodule
